/* design/buzcue_pkg.sv */
`timescale 1ns / 1ps
// Package for the buzzer cue sequencer: operation codes, engine phase,
// status struct and the constant pulse-pattern ROM. No dependencies.
package buzcue_pkg;

    localparam int TIMER_WIDTH_DEF   = 16;
    localparam int INTERVAL_WIDTH    = 16;
    localparam logic [INTERVAL_WIDTH-1:0] IDLE_INTERVAL_RST = 16'd2000;
    localparam int ROM_TIME_WIDTH    = 8;
    localparam int IN_DATA_WIDTH     = 8;
    localparam int IN_USER_WIDTH     = 3;
    localparam int OUT_DATA_WIDTH    = 8;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_PLAY_CUE   = 3'd1,
        OP_QUEUE_NOTE = 3'd2,
        OP_IDLE_START = 3'd3,
        OP_IDLE_STOP  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        PH_FREE = 2'd0,
        PH_ON   = 2'd1,
        PH_GAP  = 2'd2
    } t_phase;

    localparam logic [2:0] CUE_LAST   = 3'd4;
    localparam logic [2:0] SEL_NOTICE = 3'd5;
    localparam logic [2:0] SEL_IDLE   = 3'd6;

    typedef struct packed {
        logic notify_pending;
        logic idle_active;
        logic busy_res;
        logic buzzer_on;
    } t_status;

    function automatic logic [ROM_TIME_WIDTH-1:0] rom_on(input logic [2:0] sel,
                                                         input logic idx);
        logic [ROM_TIME_WIDTH-1:0] t;
        unique case (sel)
            3'd0:    t = 8'd200;
            3'd1:    t = 8'd100;
            3'd2:    t = 8'd90;
            3'd3:    t = 8'd250;
            3'd4:    t = 8'd150;
            3'd5:    t = idx ? 8'd0 : 8'd60;
            3'd6:    t = idx ? 8'd0 : 8'd70;
            default: t = 8'd200;
        endcase
        if (idx && (sel == 3'd0 || sel == 3'd1 || sel == 3'd3 || sel == 3'd7)) begin
            t = 8'd0;
        end
        return t;
    endfunction

    function automatic logic [ROM_TIME_WIDTH-1:0] rom_gap(input logic [2:0] sel,
                                                          input logic idx);
        logic [ROM_TIME_WIDTH-1:0] t;
        unique case (sel)
            3'd2:    t = idx ? 8'd0 : 8'd90;
            3'd4:    t = idx ? 8'd0 : 8'd100;
            default: t = 8'd0;
        endcase
        return t;
    endfunction

    function automatic logic rom_two_pulses(input logic [2:0] sel);
        return (sel == 3'd2) || (sel == 3'd4);
    endfunction

endpackage

/* design/buzcue_engine.sv */
`timescale 1ns / 1ps
// Pattern engine: phase, pattern and timer state with the per-item update.
// Depends on buzcue_pkg.
module buzcue_engine #(
    parameter int TIMER_WIDTH = buzcue_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_fire,
    input  logic [2:0]                             i_op,
    input  logic [2:0]                             i_cue,
    input  logic [buzcue_pkg::INTERVAL_WIDTH-1:0]  i_interval,
    output buzcue_pkg::t_status                    o_status
);
    import buzcue_pkg::*;

    localparam int CW = (TIMER_WIDTH > INTERVAL_WIDTH) ? TIMER_WIDTH : INTERVAL_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_sel, n_sel;
    logic                   r_idx, n_idx;
    logic [TIMER_WIDTH-1:0] r_phase_el, n_phase_el;
    logic                   r_pending, n_pending;
    logic                   r_idle_en, n_idle_en;
    logic [TIMER_WIDTH-1:0] r_idle_el, n_idle_el;
    logic                   r_drive, n_drive;

    logic [CW-1:0]          w_int_ext;
    logic [TIMER_WIDTH-1:0] w_eff_int;
    logic [TIMER_WIDTH-1:0] w_pe_inc, w_ie_inc;
    logic [TIMER_WIDTH-1:0] w_on_t, w_gap_t;

    assign w_int_ext = CW'(i_interval);
    assign w_eff_int = (w_int_ext > CW'(TMAX)) ? TMAX : w_int_ext[TIMER_WIDTH-1:0];
    assign w_pe_inc  = (r_phase_el == TMAX) ? r_phase_el : r_phase_el + 1'b1;
    assign w_ie_inc  = (r_idle_el == TMAX) ? r_idle_el : r_idle_el + 1'b1;
    assign w_on_t    = {{(TIMER_WIDTH-ROM_TIME_WIDTH){1'b0}}, rom_on(r_sel, r_idx)};
    assign w_gap_t   = {{(TIMER_WIDTH-ROM_TIME_WIDTH){1'b0}}, rom_gap(r_sel, r_idx)};

    always_comb begin
        n_phase    = r_phase;
        n_sel      = r_sel;
        n_idx      = r_idx;
        n_phase_el = r_phase_el;
        n_pending  = r_pending;
        n_idle_en  = r_idle_en;
        n_idle_el  = r_idle_el;
        n_drive    = r_drive;
        if (i_fire) begin
            unique case (i_op)
                OP_TICK: begin
                    n_phase_el = w_pe_inc;
                    n_idle_el  = w_ie_inc;
                    unique case (r_phase)
                        PH_ON: begin
                            if (w_pe_inc >= w_on_t) begin
                                n_drive    = 1'b0;
                                n_phase_el = '0;
                                if ((w_gap_t != '0) && !r_idx && rom_two_pulses(r_sel)) begin
                                    n_phase = PH_GAP;
                                end else begin
                                    n_phase = PH_FREE;
                                end
                            end
                        end
                        PH_GAP: begin
                            if (w_pe_inc >= w_gap_t) begin
                                n_idx      = ~r_idx;
                                n_drive    = 1'b1;
                                n_phase    = PH_ON;
                                n_phase_el = '0;
                            end
                        end
                        default: n_phase = PH_FREE;
                    endcase
                    if (n_phase == PH_FREE) begin
                        if (r_pending) begin
                            n_pending  = 1'b0;
                            n_sel      = SEL_NOTICE;
                            n_idx      = 1'b0;
                            n_drive    = 1'b1;
                            n_phase    = PH_ON;
                            n_phase_el = '0;
                        end else if (r_idle_en && (w_ie_inc >= w_eff_int)) begin
                            n_idle_el  = '0;
                            n_sel      = SEL_IDLE;
                            n_idx      = 1'b0;
                            n_drive    = 1'b1;
                            n_phase    = PH_ON;
                            n_phase_el = '0;
                        end
                    end
                end
                OP_PLAY_CUE: begin
                    if (i_cue <= CUE_LAST) begin
                        n_sel      = i_cue;
                        n_idx      = 1'b0;
                        n_drive    = 1'b1;
                        n_phase    = PH_ON;
                        n_phase_el = '0;
                    end
                end
                OP_QUEUE_NOTE: n_pending = 1'b1;
                OP_IDLE_START: begin
                    if (!r_idle_en) begin
                        n_idle_en = 1'b1;
                        n_idle_el = w_eff_int;
                    end
                end
                OP_IDLE_STOP: n_idle_en = 1'b0;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_status.buzzer_on      = n_drive;
        o_status.busy_res       = (n_phase == PH_ON) || (n_phase == PH_GAP);
        o_status.idle_active    = n_idle_en;
        o_status.notify_pending = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FREE;
            r_sel      <= '0;
            r_idx      <= 1'b0;
            r_phase_el <= '0;
            r_pending  <= 1'b0;
            r_idle_en  <= 1'b0;
            r_idle_el  <= '0;
            r_drive    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_sel      <= n_sel;
            r_idx      <= n_idx;
            r_phase_el <= n_phase_el;
            r_pending  <= n_pending;
            r_idle_en  <= n_idle_en;
            r_idle_el  <= n_idle_el;
            r_drive    <= n_drive;
        end
    end

endmodule

/* design/buzzer_cue_sequencer.sv */
`timescale 1ns / 1ps
// Buzzer cue sequencer top level: input register, pattern engine, result register
// and the idle interval register. Depends on buzcue_pkg and buzcue_engine.
//
// Usage:
//   Slave stream: tuser carries the operation (tick, play cue, queue
//   notification, start idle, stop idle); tdata carries the cue index.
//   Each transfer yields exactly one result on the master stream: tdata
//   holds buzzer_on, busy_res, idle_active and notify_pending after the item.
//   The idle interval register is written with i_cfg_we / i_cfg_wdata and
//   should only change while no transfer is in flight.
// Path: the input register loads on the transfer, and the engine update then
//   lands in the result register once that register is empty or being taken.
// Throughput: one transfer per cycle unless stalled; the engine state update
//   is a single compare-and-select step between the input and result registers.
// Reset: synchronous, active low; buzzer off, engine free, idle warning off,
//   no notification pending, interval 2000 ticks, both registers empty.
// Stall: while the result is not taken, the input register holds one more
//   item and tready drops only when both registers are full.
module buzzer_cue_sequencer #(
    parameter int TIMER_WIDTH = buzcue_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [buzcue_pkg::INTERVAL_WIDTH-1:0]  i_cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [buzcue_pkg::IN_DATA_WIDTH-1:0]   s_axis_tdata,  // [2:0] cue
    input  logic [buzcue_pkg::IN_USER_WIDTH-1:0]   s_axis_tuser,  // [2:0] operation
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [buzcue_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata   // [0] buzzer_on,
                                                                  // [1] busy_res,
                                                                  // [2] idle_active,
                                                                  // [3] notify_pending
);
    import buzcue_pkg::*;

    logic [INTERVAL_WIDTH-1:0] r_interval;
    logic                      r_in_valid;
    logic [2:0]                r_in_op;
    logic [2:0]                r_in_cue;
    logic                      r_out_valid;
    t_status                   r_out_status;
    t_status                   w_status;
    logic                      w_fire;

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_WIDTH-4){1'b0}}, r_out_status};

    buzcue_engine #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_op       (r_in_op),
        .i_cue      (r_in_cue),
        .i_interval (r_interval),
        .o_status   (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= IDLE_INTERVAL_RST;
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op  <= s_axis_tuser;
            r_in_cue <= s_axis_tdata[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_status <= w_status;
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for buzzer_cue_sequencer: random stream traffic with stalls on both
// sides, a bit-true status predictor and in-order compare. Depends on buzcue_pkg.
module tb_top;
    import buzcue_pkg::*;

    localparam logic [2:0] OP_RSVD_LO      = 3'd5;
    localparam logic [2:0] OP_RSVD_HI      = 3'd7;
    localparam logic [2:0] CUE_START_FOCUS = 3'd0;
    localparam logic [2:0] CUE_PAUSE       = 3'd1;
    localparam logic [2:0] CUE_RESUME      = 3'd2;
    localparam logic [2:0] CUE_STOP        = 3'd3;
    localparam logic [2:0] CUE_START_BREAK = 3'd4;
    localparam logic [2:0] CUE_RSVD_LO     = 3'd5;
    localparam logic [2:0] CUE_RSVD_HI     = 3'd7;
    localparam logic [15:0] TIMER_SAT      = 16'hFFFF;

    class buzzer_status_model;
        logic [15:0] interval_ms;
        t_phase      phase;
        logic [2:0]  sel;
        logic        pulse;
        logic [15:0] phase_ms;
        logic        notice;
        logic        idle_on;
        logic [15:0] idle_ms;
        logic        drive;
        t_status     status_q[$];
        int unsigned fails;

        function new();
            interval_ms = IDLE_INTERVAL_RST;
            phase       = PH_FREE;
            sel         = '0;
            pulse       = 1'b0;
            phase_ms    = '0;
            notice      = 1'b0;
            idle_on     = 1'b0;
            idle_ms     = '0;
            drive       = 1'b0;
            fails       = 0;
        endfunction

        function logic [7:0] on_ms(logic [2:0] s);
            case (s)
                3'd0:    return 8'd200;
                3'd1:    return 8'd100;
                3'd2:    return 8'd90;
                3'd3:    return 8'd250;
                3'd4:    return 8'd150;
                SEL_NOTICE: return 8'd60;
                default: return 8'd70;
            endcase
        endfunction

        function logic [7:0] gap_ms(logic [2:0] s, logic idx);
            if (idx) return 8'd0;
            case (s)
                3'd2:    return 8'd90;
                3'd4:    return 8'd100;
                default: return 8'd0;
            endcase
        endfunction

        function void start_pattern(logic [2:0] s);
            sel      = s;
            pulse    = 1'b0;
            drive    = 1'b1;
            phase    = PH_ON;
            phase_ms = '0;
        endfunction

        function void tick();
            phase_ms = (phase_ms == TIMER_SAT) ? phase_ms : phase_ms + 16'd1;
            idle_ms  = (idle_ms == TIMER_SAT) ? idle_ms : idle_ms + 16'd1;
            if (phase == PH_ON) begin
                if (phase_ms >= on_ms(sel)) begin
                    drive    = 1'b0;
                    phase_ms = '0;
                    if (gap_ms(sel, pulse) != 0) phase = PH_GAP;
                    else phase = PH_FREE;
                end
            end else if (phase == PH_GAP) begin
                if (phase_ms >= gap_ms(sel, pulse)) begin
                    pulse    = ~pulse;
                    drive    = 1'b1;
                    phase    = PH_ON;
                    phase_ms = '0;
                end
            end else begin
                phase = PH_FREE;
            end
            if (phase == PH_FREE) begin
                if (notice) begin
                    notice = 1'b0;
                    start_pattern(SEL_NOTICE);
                end else if (idle_on && idle_ms >= interval_ms) begin
                    idle_ms = '0;
                    start_pattern(SEL_IDLE);
                end
            end
        endfunction

        function void take_item(logic [2:0] op, logic [2:0] cue);
            t_status st;
            case (op)
                OP_TICK:       tick();
                OP_PLAY_CUE:   if (cue <= CUE_LAST) start_pattern(cue);
                OP_QUEUE_NOTE: notice = 1'b1;
                OP_IDLE_START: begin
                    if (!idle_on) begin
                        idle_on = 1'b1;
                        idle_ms = interval_ms;
                    end
                end
                OP_IDLE_STOP:  idle_on = 1'b0;
                default: ;
            endcase
            st.buzzer_on      = drive;
            st.busy_res       = (phase == PH_ON || phase == PH_GAP);
            st.idle_active    = idle_on;
            st.notify_pending = notice;
            status_q.push_back(st);
        endfunction

        function void compare_bit(string name, logic want, logic got);
            if (got !== want) begin
                $error("%s: expected %0b, got %0b", name, want, got);
                fails++;
            end
        endfunction

        function void check_status(t_status got);
            t_status want;
            if (status_q.size() == 0) begin
                $error("unexpected result %b with nothing outstanding", got);
                fails++;
                return;
            end
            want = status_q.pop_front();
            compare_bit("buzzer_on", want.buzzer_on, got.buzzer_on);
            compare_bit("busy_res", want.busy_res, got.busy_res);
            compare_bit("idle_active", want.idle_active, got.idle_active);
            compare_bit("notify_pending", want.notify_pending, got.notify_pending);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [2:0] cue
    logic [2:0]  s_axis_tuser = '0;   // [2:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [0] buzzer_on, [1] busy_res, [2] idle_active,
                                      // [3] notify_pending
    bit          quiet_flow = 1'b0;
    buzzer_status_model sb;

    always #5 i_clk = ~i_clk;

    buzzer_cue_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    task automatic send_item(input logic [2:0] op, input logic [2:0] cue);
        int unsigned hold;
        hold = quiet_flow ? 0 : $urandom_range(0, 17);
        if (hold != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (hold) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, cue};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_item(op, cue);
    endtask

    task automatic send_random(input int unsigned tick_permil);
        int unsigned r;
        logic [2:0]  op;
        logic [2:0]  cue;
        cue = 3'($urandom_range(0, 7));
        r   = $urandom_range(0, 999);
        if (r < tick_permil) begin
            op = OP_TICK;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                op  = OP_PLAY_CUE;
                cue = ($urandom_range(0, 9) < 8)
                    ? 3'($urandom_range(0, CUE_LAST))
                    : 3'($urandom_range(CUE_RSVD_LO, CUE_RSVD_HI));
            end else if (r < 60) begin
                op = OP_QUEUE_NOTE;
            end else if (r < 80) begin
                op = OP_IDLE_START;
            end else if (r < 90) begin
                op = OP_IDLE_STOP;
            end else begin
                op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
            end
        end
        send_item(op, cue);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [15:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.interval_ms = value;
    endtask

    task automatic run_phase(input logic [15:0] value, input int unsigned count,
                             input int unsigned tick_permil, input bit quiet);
        write_interval(value);
        quiet_flow = quiet;
        repeat (count) send_random(tick_permil);
    endtask

    initial begin
        int unsigned hold;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = quiet_flow ? 0 : $urandom_range(0, 17);
            if (hold != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_status(t_status'(m_axis_tdata[3:0]));
        end
    end

    initial begin
        #10_000_000;
        $display("buzzer_cue_sequencer regression: fail");
        $finish;
    end

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_TICK, CUE_RSVD_HI);
        send_item(OP_PLAY_CUE, CUE_START_FOCUS);
        send_item(OP_TICK, CUE_START_FOCUS);
        send_item(OP_PLAY_CUE, CUE_PAUSE);
        send_item(OP_TICK, CUE_PAUSE);
        send_item(OP_PLAY_CUE, CUE_RESUME);
        send_item(OP_PLAY_CUE, CUE_STOP);
        send_item(OP_PLAY_CUE, CUE_START_BREAK);
        send_item(OP_PLAY_CUE, CUE_RSVD_LO);
        send_item(OP_PLAY_CUE, CUE_RSVD_LO + 3'd1);
        send_item(OP_PLAY_CUE, CUE_RSVD_HI);
        send_item(OP_RSVD_LO, CUE_START_FOCUS);
        send_item(OP_RSVD_LO + 3'd1, CUE_RSVD_HI);
        send_item(OP_RSVD_HI, CUE_STOP);
        send_item(OP_QUEUE_NOTE, CUE_RSVD_HI);
        send_item(OP_QUEUE_NOTE, CUE_START_FOCUS);
        send_item(OP_IDLE_START, CUE_PAUSE);
        send_item(OP_IDLE_START, CUE_RESUME);
        send_item(OP_IDLE_STOP, CUE_START_BREAK);
        send_item(OP_IDLE_STOP, CUE_STOP);
        send_item(OP_IDLE_START, CUE_RSVD_LO);
        send_item(OP_TICK, CUE_RSVD_HI);
        send_item(OP_TICK, CUE_START_FOCUS);

        run_phase(16'd1, 300, 970, 1'b0);
        run_phase(16'd0, 250, 900, 1'b0);
        run_phase(16'hFFFF, 250, 800, 1'b0);
        run_phase(16'($urandom_range(50, 400)), 300, 985, 1'b1);
        run_phase(IDLE_INTERVAL_RST, 200, 950, 1'b0);
        run_phase(16'($urandom_range(1, 150)), 300, 990, 1'b0);

        // full-range interval: the first reminder fires on the next free tick
        write_interval(16'hFFFF);
        quiet_flow = 1'b1;
        send_item(OP_IDLE_START, CUE_START_FOCUS);
        repeat (60) send_item(OP_TICK, 3'($urandom_range(0, 7)));
        quiet_flow = 1'b0;
        repeat (40) send_random(900);

        wait_drained();
        if (sb.fails == 0 && sb.status_q.size() == 0) begin
            $display("buzzer_cue_sequencer regression: pass");
        end else begin
            $display("buzzer_cue_sequencer regression: fail");
        end
        $finish;
    end
endmodule
